>>> sv/frc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_pkg: shared types and constants
// Beat types, character codes, verdict and event matcher codes.
// ----------------------------------------------------------------------------
package frc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } frc_in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] frame_opcode;
    logic [16:0] frame_length;
  } frc_out_t;

  typedef struct packed {
    logic pay;    // payload byte is processed this cycle
    logic clr;    // clear frame state
    logic first;  // first payload byte of the frame
  } frc_ctl_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_CTRL_LIM = 8'h20;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_E      = 8'h45;

  localparam logic [1:0] VERD_OK    = 2'd0;
  localparam logic [1:0] VERD_READY = 2'd1;
  localparam logic [1:0] VERD_PING  = 2'd2;
  localparam logic [1:0] VERD_CLOSE = 2'd3;

  localparam logic [31:0] OP_JSON = 32'd1;
  localparam logic [31:0] OP_PING = 32'd3;
  localparam logic [31:0] OP_PONG = 32'd4;

  localparam int unsigned HDR_BYTES = 8;
  localparam logic [16:0] LEN_SAT  = 17'h1FFFF;

  // event matcher result codes
  localparam logic [2:0] EVM_UNDEC   = 3'd0;
  localparam logic [2:0] EVM_NONE    = 3'd1;
  localparam logic [2:0] EVM_READY   = 3'd2;
  localparam logic [2:0] EVM_ERROR   = 3'd3;
  localparam logic [2:0] EVM_M_READY = 3'd4;
  localparam logic [2:0] EVM_M_ERROR = 3'd5;

  // key matcher phases
  localparam logic [3:0] PH_KEY_DONE = 4'd5;
  localparam logic [3:0] PH_KEY_BLNK = 4'd6;
  localparam logic [3:0] PH_COLON    = 4'd7;
  localparam logic [3:0] PH_VAL_Q    = 4'd8;
  localparam logic [3:0] PH_VAL_1    = 4'd9;
  localparam logic [3:0] PH_VAL_4    = 4'd12;
  localparam logic [3:0] PH_VAL_END  = 4'd13;
  localparam logic [3:0] PH_DECIDED  = 4'd15;

  function automatic logic [7:0] key_char(input logic [2:0] k);
    case (k)
      3'd0:    key_char = CH_QUOTE;
      3'd1:    key_char = 8'h65;
      3'd2:    key_char = 8'h76;
      3'd3:    key_char = 8'h74;
      3'd4:    key_char = CH_QUOTE;
      default: key_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] word_char(input logic is_ready, input logic [1:0] idx);
    logic [7:0] r;
    logic [7:0] e;
    case (idx)
      2'd0:    begin r = 8'h45; e = 8'h52; end
      2'd1:    begin r = 8'h41; e = 8'h52; end
      2'd2:    begin r = 8'h44; e = 8'h4F; end
      default: begin r = 8'h59; e = 8'h52; end
    endcase
    word_char = is_ready ? r : e;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

>>> sv/frc_json_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_json_chk: streaming JSON structure check
// Tracks strings, escapes, nesting depth and control bytes per payload byte.
// ----------------------------------------------------------------------------
module frc_json_chk #(
  parameter int unsigned DEPTH_W = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  frc_pkg::frc_ctl_t ctl,
  input  logic [7:0]        data_byte,
  output logic              json_ok
);
  import frc_pkg::*;

  logic               str_r, str_nxt;
  logic               esc_r, esc_nxt;
  logic               bad_r, bad_nxt;
  logic               last_r, last_nxt;
  logic [DEPTH_W-1:0] dep_r, dep_nxt;

  logic               str_f, esc_f, bad_f, last_f;
  logic [DEPTH_W-1:0] dep_f;

  always_comb begin
    str_nxt  = str_r;
    esc_nxt  = esc_r;
    bad_nxt  = bad_r;
    dep_nxt  = dep_r;
    last_nxt = (data_byte == CH_RBRACE);
    if (ctl.first && data_byte != CH_LBRACE) begin
      bad_nxt = 1'b1;
    end
    if (str_r) begin
      if (data_byte < CH_CTRL_LIM) begin
        bad_nxt = 1'b1;
      end
      if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (data_byte == CH_BSLASH) begin
        esc_nxt = 1'b1;
      end else if (data_byte == CH_QUOTE) begin
        str_nxt = 1'b0;
      end
    end else if (data_byte == CH_QUOTE) begin
      str_nxt = 1'b1;
    end else if (data_byte == CH_LBRACE || data_byte == CH_LBRACK) begin
      dep_nxt = dep_r + 1'b1;
    end else if (data_byte == CH_RBRACE || data_byte == CH_RBRACK) begin
      if (dep_r == '0) begin
        bad_nxt = 1'b1;
      end else begin
        dep_nxt = dep_r - 1'b1;
      end
    end else if (data_byte < CH_CTRL_LIM && data_byte != CH_TAB &&
                 data_byte != CH_LF && data_byte != CH_CR) begin
      bad_nxt = 1'b1;
    end
  end

  // values after this beat, used when the frame ends on it
  always_comb begin
    str_f  = ctl.pay ? str_nxt  : str_r;
    esc_f  = ctl.pay ? esc_nxt  : esc_r;
    bad_f  = ctl.pay ? bad_nxt  : bad_r;
    last_f = ctl.pay ? last_nxt : last_r;
    dep_f  = ctl.pay ? dep_nxt  : dep_r;
  end

  assign json_ok = !bad_f && !str_f && !esc_f && last_f && (dep_f == '0);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      str_r  <= 1'b0;
      esc_r  <= 1'b0;
      bad_r  <= 1'b0;
      last_r <= 1'b0;
      dep_r  <= '0;
    end else if (ctl.pay) begin
      str_r  <= str_nxt;
      esc_r  <= esc_nxt;
      bad_r  <= bad_nxt;
      last_r <= last_nxt;
      dep_r  <= dep_nxt;
    end
  end

endmodule

>>> sv/frc_evt_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_evt_match: event key and value matcher
// Finds the first "evt" key followed by a colon and matches READY or ERROR.
// ----------------------------------------------------------------------------
module frc_evt_match (
  input  logic              clk,
  input  logic              rst_n,
  input  frc_pkg::frc_ctl_t ctl,
  input  logic [7:0]        data_byte,
  output logic [2:0]        evt_code
);
  import frc_pkg::*;

  logic [3:0] ph_r, ph_nxt;
  logic [2:0] evm_r, evm_nxt;
  logic [3:0] srch0, srch1, restart_q;
  logic       is_rdy;

  always_comb begin
    srch0     = (data_byte == CH_QUOTE) ? 4'd1 : 4'd0;
    srch1     = (data_byte == key_char(3'd1)) ? 4'd2 : srch0;
    restart_q = srch0;
    is_rdy    = (evm_r == EVM_M_READY);
    ph_nxt    = ph_r;
    evm_nxt   = evm_r;
    if (evm_r == EVM_NONE || evm_r == EVM_READY || evm_r == EVM_ERROR ||
        ph_r == PH_DECIDED) begin
      ph_nxt = ph_r;
    end else if (ph_r <= 4'd4) begin
      ph_nxt = (data_byte == key_char(ph_r[2:0])) ? ph_r + 4'd1 : srch0;
    end else if (ph_r == PH_KEY_DONE || ph_r == PH_KEY_BLNK) begin
      if (is_blank(data_byte)) begin
        ph_nxt = PH_KEY_BLNK;
      end else if (data_byte == CH_COLON) begin
        ph_nxt = PH_COLON;
      end else if (ph_r == PH_KEY_DONE) begin
        ph_nxt = srch1;
      end else begin
        ph_nxt = restart_q;
      end
    end else if (ph_r == PH_COLON) begin
      if (data_byte == CH_QUOTE) begin
        ph_nxt = PH_VAL_Q;
      end else if (!is_blank(data_byte)) begin
        ph_nxt  = PH_DECIDED;
        evm_nxt = EVM_NONE;
      end
    end else if (ph_r == PH_VAL_Q) begin
      if (data_byte == CH_R) begin
        evm_nxt = EVM_M_READY;
        ph_nxt  = PH_VAL_1;
      end else if (data_byte == CH_E) begin
        evm_nxt = EVM_M_ERROR;
        ph_nxt  = PH_VAL_1;
      end else begin
        ph_nxt  = PH_DECIDED;
        evm_nxt = EVM_NONE;
      end
    end else if (ph_r >= PH_VAL_1 && ph_r <= PH_VAL_4) begin
      if (data_byte == word_char(is_rdy, 2'(ph_r - PH_VAL_1))) begin
        ph_nxt = ph_r + 4'd1;
      end else begin
        ph_nxt  = PH_DECIDED;
        evm_nxt = EVM_NONE;
      end
    end else if (ph_r == PH_VAL_END) begin
      ph_nxt = PH_DECIDED;
      if (data_byte == CH_QUOTE) begin
        evm_nxt = is_rdy ? EVM_READY : EVM_ERROR;
      end else begin
        evm_nxt = EVM_NONE;
      end
    end else begin
      ph_nxt  = PH_DECIDED;
      evm_nxt = EVM_NONE;
    end
  end

  assign evt_code = ctl.pay ? evm_nxt : evm_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      ph_r  <= '0;
      evm_r <= EVM_UNDEC;
    end else if (ctl.pay) begin
      ph_r  <= ph_nxt;
      evm_r <= evm_nxt;
    end
  end

endmodule

>>> sv/ipc_frame_receiver_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_frame_receiver_classifier: frame receiver and verdict classifier
// Deframes an 8-byte opcode/length header, checks JSON payloads and emits
// one verdict beat per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one stream byte per
//   beat plus a restart flag that clears all parse state before the byte.
//   Output channel (out_valid/out_stall/out_data) carries one verdict beat
//   at the end of each frame, or at the eighth header byte for an empty or
//   oversize payload. Most beats produce no output.
//   Throughput: one byte per cycle while in_stall is low. A byte is
//   registered in the input register, then parsed into the output register,
//   where its verdict becomes valid.
//   After a close verdict the stream is dead and bytes are dropped until a
//   beat with restart set.
//   When the receiver stalls with a verdict pending, bytes that produce no
//   verdict keep flowing; the next verdict-producing byte waits in the input
//   register and in_stall rises.
//   Reset clears all parse state and empties both registers.
// ----------------------------------------------------------------------------
module ipc_frame_receiver_classifier #(
  parameter int unsigned MAX_PAYLOAD = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  frc_pkg::frc_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output frc_pkg::frc_out_t out_data
);
  import frc_pkg::*;

  localparam int unsigned PW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [31:0] MAX_LEN = 32'(MAX_PAYLOAD);
  localparam logic [16:0] MAX_LEN_SAT = (MAX_PAYLOAD > 32'h1FFFF) ? LEN_SAT
                                                                  : 17'(MAX_PAYLOAD);

  logic              s1_valid_r;
  frc_in_t           s1_beat_r;
  logic              out_valid_r;
  frc_out_t          out_beat_r;

  logic [3:0]        hc_r;
  logic [31:0]       op_r, len_r;
  logic [PW-1:0]     pc_r;
  logic              dead_r;

  logic [3:0]        hc_cur, hc_inc;
  logic [31:0]       op_cur, len_cur, op_asm, len_asm, byte_sh;
  logic [PW-1:0]     pc_cur, pc_inc;
  logic              dead_cur, hdr, pay, hdr_done, oversize;
  logic              fin, rej, has_res, go, out_free;
  logic              json_ok, json_good;
  logic [2:0]        evt_code;
  logic [1:0]        verdict;
  logic [16:0]       len_out;
  frc_ctl_t          ctl;

  always_comb begin
    hc_cur   = s1_beat_r.restart ? '0 : hc_r;
    op_cur   = s1_beat_r.restart ? '0 : op_r;
    len_cur  = s1_beat_r.restart ? '0 : len_r;
    pc_cur   = s1_beat_r.restart ? '0 : pc_r;
    dead_cur = s1_beat_r.restart ? 1'b0 : dead_r;

    hdr      = !dead_cur && !hc_cur[3];
    pay      = !dead_cur && hc_cur[3];
    hc_inc   = hc_cur + 4'd1;
    byte_sh  = {24'd0, s1_beat_r.data_byte} << {hc_cur[1:0], 3'b000};
    op_asm   = (hdr && !hc_cur[2]) ? (op_cur | byte_sh) : op_cur;
    len_asm  = (hdr && hc_cur[2]) ? (len_cur | byte_sh) : len_cur;
    hdr_done = hdr && (hc_inc == 4'(HDR_BYTES));
    oversize = len_asm > MAX_LEN;
    pc_inc   = pc_cur + 1'b1;

    rej     = hdr_done && oversize;
    fin     = (hdr_done && !oversize && len_asm == '0) ||
              (pay && (pc_inc >= len_cur[PW-1:0]));
    has_res = fin || rej;

    json_good = json_ok && (len_asm >= 32'd2);
    if (rej) begin
      verdict = VERD_CLOSE;
    end else if (op_asm == OP_PING) begin
      verdict = VERD_PING;
    end else if (op_asm == OP_PONG) begin
      verdict = VERD_OK;
    end else if (op_asm == OP_JSON) begin
      if (!json_good || evt_code == EVM_ERROR) begin
        verdict = VERD_CLOSE;
      end else if (evt_code == EVM_READY) begin
        verdict = VERD_READY;
      end else begin
        verdict = VERD_OK;
      end
    end else begin
      verdict = VERD_CLOSE;
    end

    if (rej) begin
      len_out = MAX_LEN_SAT;
    end else if (len_asm > {15'd0, LEN_SAT}) begin
      len_out = LEN_SAT;
    end else begin
      len_out = len_asm[16:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign go       = s1_valid_r && (!has_res || out_free);
  assign in_stall = s1_valid_r && !go;

  assign ctl.pay   = go && pay;
  assign ctl.clr   = go && (s1_beat_r.restart || has_res);
  assign ctl.first = (pc_cur == '0);

  frc_json_chk #(
    .DEPTH_W (PW)
  ) u_json (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .data_byte (s1_beat_r.data_byte),
    .json_ok   (json_ok)
  );

  frc_evt_match u_evt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .data_byte (s1_beat_r.data_byte),
    .evt_code  (evt_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_beat_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r   <= '0;
      op_r   <= '0;
      len_r  <= '0;
      pc_r   <= '0;
      dead_r <= 1'b0;
    end else if (go) begin
      if (has_res) begin
        hc_r  <= '0;
        op_r  <= '0;
        len_r <= '0;
        pc_r  <= '0;
      end else begin
        hc_r  <= hdr ? hc_inc : hc_cur;
        op_r  <= op_asm;
        len_r <= len_asm;
        pc_r  <= pay ? pc_inc : pc_cur;
      end
      dead_r <= dead_cur || (has_res && verdict == VERD_CLOSE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && has_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && has_res) begin
      out_beat_r.verdict      <= verdict;
      out_beat_r.frame_opcode <= op_asm;
      out_beat_r.frame_length <= len_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

endmodule

>>> sv/frc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_checker: port-level checks for the frame classifier
// Output beat handshake and verdict consistency, bound to the top level.
// ----------------------------------------------------------------------------
module frc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input frc_pkg::frc_out_t out_data
);
  import frc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("output beat changed while stalled");

  // an oversize ping header is closed
  a_ping: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_opcode == OP_PING
      |-> out_data.verdict == VERD_PING || out_data.verdict == VERD_CLOSE)
    else $error("ping frame without ping verdict");

  a_pong: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_opcode == OP_PONG && out_data.frame_length != 17'd0
      |-> out_data.verdict == VERD_OK || out_data.verdict == VERD_CLOSE)
    else $error("pong frame with wrong verdict");

  a_short_json: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_opcode == OP_JSON && out_data.frame_length < 17'd2
      |-> out_data.verdict == VERD_CLOSE)
    else $error("short JSON frame not closed");

endmodule

bind ipc_frame_receiver_classifier frc_checker u_frc_checker (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for ipc_frame_receiver_classifier
// Sends framed byte streams (headers, JSON payloads with and without an
// event key, ping/pong/other opcodes, oversize lengths, dead-stream bytes,
// restarts and noise), predicts each frame verdict beat, and compares every
// output beat field by field, under random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import frc_pkg::*;

  localparam int unsigned MAX_PAY     = 65536;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [39:0] KEY_SEQ     = "\"evt\"";
  localparam logic [39:0] WORD_READY  = "READY";
  localparam logic [39:0] WORD_ERROR  = "ERROR";

  class verdict_tracker;
    logic [31:0] op_acc;
    logic [31:0] len_acc;
    logic [31:0] pay_cnt;
    logic [31:0] depth;
    int unsigned hdr_cnt;
    logic        in_str;
    logic        esc;
    logic        bad;
    logic        last_rb;
    logic        dead;
    logic [3:0]  phase;
    logic [2:0]  evm;
    frc_out_t    verdicts_due[$];
    int unsigned live_bytes;
    int unsigned verdicts_seen;
    int unsigned failures;

    function new();
      clear_frame();
      dead          = 1'b0;
      live_bytes    = 0;
      verdicts_seen = 0;
      failures      = 0;
    endfunction

    function void clear_frame();
      op_acc  = '0;
      len_acc = '0;
      pay_cnt = '0;
      depth   = '0;
      hdr_cnt = 0;
      in_str  = 1'b0;
      esc     = 1'b0;
      bad     = 1'b0;
      last_rb = 1'b0;
      phase   = '0;
      evm     = EVM_UNDEC;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function logic blank_char(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function logic [16:0] clamp_len(logic [31:0] v);
      return (v > 32'h1FFFF) ? LEN_SAT : v[16:0];
    endfunction

    function void push_verdict(logic [1:0] v, logic [16:0] l);
      frc_out_t e;
      e.verdict      = v;
      e.frame_opcode = op_acc;
      e.frame_length = l;
      verdicts_due.push_back(e);
      if (v == VERD_CLOSE) dead = 1'b1;
      clear_frame();
    endfunction

    function void close_frame();
      logic [1:0] v;
      logic       ok;
      if (op_acc == OP_PING) begin
        v = VERD_PING;
      end else if (op_acc == OP_PONG) begin
        v = VERD_OK;
      end else if (op_acc == OP_JSON) begin
        ok = (len_acc >= 2) && !bad && !in_str && !esc && last_rb && (depth == 0);
        if (!ok || evm == EVM_ERROR) v = VERD_CLOSE;
        else if (evm == EVM_READY) v = VERD_READY;
        else v = VERD_OK;
      end else begin
        v = VERD_CLOSE;
      end
      push_verdict(v, clamp_len(len_acc));
    endfunction

    function void json_step(logic [7:0] c);
      if (pay_cnt == 0 && c != CH_LBRACE) bad = 1'b1;
      last_rb = (c == CH_RBRACE);
      if (in_str) begin
        if (c < CH_CTRL_LIM) bad = 1'b1;
        if (esc) esc = 1'b0;
        else if (c == CH_BSLASH) esc = 1'b1;
        else if (c == CH_QUOTE) in_str = 1'b0;
      end else if (c == CH_QUOTE) begin
        in_str = 1'b1;
      end else if (c == CH_LBRACE || c == CH_LBRACK) begin
        depth++;
      end else if (c == CH_RBRACE || c == CH_RBRACK) begin
        if (depth == 0) bad = 1'b1;
        else depth--;
      end else if (c < CH_CTRL_LIM && c != CH_TAB && c != CH_LF && c != CH_CR) begin
        bad = 1'b1;
      end
    endfunction

    function logic [3:0] key_advance(int unsigned k, logic [7:0] c);
      if (k < 5 && c == KEY_SEQ[8*(4-k) +: 8]) return 4'(k + 1);
      return (c == CH_QUOTE) ? 4'd1 : 4'd0;
    endfunction

    function void settle(logic [2:0] v);
      evm   = v;
      phase = PH_DECIDED;
    endfunction

    function void event_step(logic [7:0] c);
      int unsigned idx;
      logic [7:0]  want;
      if (evm == EVM_NONE || evm == EVM_READY || evm == EVM_ERROR || phase == PH_DECIDED)
        return;
      if (phase < PH_KEY_DONE) begin
        phase = key_advance(32'(phase), c);
      end else if (phase == PH_KEY_DONE || phase == PH_KEY_BLNK) begin
        if (blank_char(c)) phase = PH_KEY_BLNK;
        else if (c == CH_COLON) phase = PH_COLON;
        else if (phase == PH_KEY_DONE) phase = key_advance(1, c);
        else phase = (c == CH_QUOTE) ? 4'd1 : 4'd0;
      end else if (phase == PH_COLON) begin
        if (c == CH_QUOTE) phase = PH_VAL_Q;
        else if (!blank_char(c)) settle(EVM_NONE);
      end else if (phase == PH_VAL_Q) begin
        if (c == CH_R) begin
          evm   = EVM_M_READY;
          phase = PH_VAL_1;
        end else if (c == CH_E) begin
          evm   = EVM_M_ERROR;
          phase = PH_VAL_1;
        end else begin
          settle(EVM_NONE);
        end
      end else if (phase >= PH_VAL_1 && phase <= PH_VAL_4) begin
        idx  = 32'(phase - PH_VAL_Q);
        want = (evm == EVM_M_READY) ? WORD_READY[8*(4-idx) +: 8]
                                    : WORD_ERROR[8*(4-idx) +: 8];
        if (c == want) phase = phase + 4'd1;
        else settle(EVM_NONE);
      end else if (phase == PH_VAL_END) begin
        if (c == CH_QUOTE) settle((evm == EVM_M_READY) ? EVM_READY : EVM_ERROR);
        else settle(EVM_NONE);
      end else begin
        settle(EVM_NONE);
      end
    endfunction

    // one accepted input beat
    function void take_byte(frc_in_t d);
      logic [7:0] c;
      c = d.data_byte;
      if (d.restart) begin
        clear_frame();
        dead = 1'b0;
      end
      if (dead) return;
      live_bytes++;
      if (hdr_cnt < HDR_BYTES) begin
        if (hdr_cnt < 4) op_acc[8*hdr_cnt +: 8] = c;
        else len_acc[8*(hdr_cnt-4) +: 8] = c;
        hdr_cnt++;
        if (hdr_cnt == HDR_BYTES) begin
          if (len_acc > MAX_PAY) push_verdict(VERD_CLOSE, clamp_len(MAX_PAY));
          else if (len_acc == 0) close_frame();
        end
        return;
      end
      json_step(c);
      event_step(c);
      pay_cnt++;
      if (pay_cnt >= len_acc) close_frame();
    endfunction

    // one accepted output beat
    function void match_verdict(frc_out_t got);
      frc_out_t want;
      verdicts_seen++;
      if (verdicts_due.size() == 0) begin
        flag($sformatf("unexpected verdict beat: verdict %0d opcode %h length %h",
                       got.verdict, got.frame_opcode, got.frame_length));
        return;
      end
      want = verdicts_due.pop_front();
      if (got.verdict !== want.verdict)
        flag($sformatf("verdict mismatch: expected %0d, got %0d (opcode %h)",
                       want.verdict, got.verdict, want.frame_opcode));
      if (got.frame_opcode !== want.frame_opcode)
        flag($sformatf("opcode mismatch: expected %h, got %h",
                       want.frame_opcode, got.frame_opcode));
      if (got.frame_length !== want.frame_length)
        flag($sformatf("length mismatch: expected %h, got %h (opcode %h)",
                       want.frame_length, got.frame_length, want.frame_opcode));
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  frc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  frc_out_t out_data;

  verdict_tracker trk = new();
  logic       tx_quiet = 1'b0;
  logic       rx_quiet = 1'b0;
  logic       hold_req = 1'b0;
  logic       resync = 1'b0;
  logic [7:0] pay_q[$];

  ipc_frame_receiver_classifier #(.MAX_PAYLOAD(MAX_PAY)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) trk.match_verdict(out_data);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= !rx_quiet && ($urandom_range(99) < 12);
    end
  end

  initial begin
    #12_000_000;
    $display("[ipc_frame_receiver_classifier] ERROR");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b, input logic rs);
    frc_in_t beat;
    beat.data_byte = b;
    beat.restart   = rs;
    while (!tx_quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    trk.take_byte(beat);
  endtask

  task automatic send_frame(input logic [31:0] op, input logic [31:0] len,
                            input logic rs, input logic brk);
    logic r;
    for (int i = 0; i < 4; i++) send_beat(op[8*i +: 8], rs && i == 0);
    for (int i = 0; i < 4; i++) send_beat(len[8*i +: 8], 1'b0);
    foreach (pay_q[i]) begin
      r = brk && ($urandom_range(199) == 0);
      if (r) resync = 1'b1;
      send_beat(pay_q[i], r);
    end
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) pay_q.push_back(s[i]);
  endtask

  task automatic put_blanks();
    repeat ($urandom_range(2)) begin
      case ($urandom_range(3))
        0: pay_q.push_back(CH_SPACE);
        1: pay_q.push_back(CH_TAB);
        2: pay_q.push_back(CH_CR);
        default: pay_q.push_back(CH_LF);
      endcase
    end
  endtask

  task automatic fill_random(input int unsigned n);
    pay_q.delete();
    repeat (n) pay_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic build_json();
    int unsigned r;
    pay_q.delete();
    put_str("{");
    put_blanks();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: put_str("\"evt\"");
      6: put_str("\"ev\"");
      7: put_str("\"\"evt\"");
      8: put_str("\"evtx\"");
      default: put_str("\"id\"");
    endcase
    put_blanks();
    if ($urandom_range(9) != 0) put_str(":");
    put_blanks();
    case ($urandom_range(9))
      0, 1, 2: put_str("\"READY\"");
      3, 4: put_str("\"ERROR\"");
      5: put_str("\"READ\"");
      6: put_str("\"ERRORS\"");
      7: put_str("\"RX\"");
      8: put_str("42");
      default: put_str("\"EROR\"");
    endcase
    if ($urandom_range(2) == 0) put_str(",\"d\":[1,{\"s\":\"a\\\"b\\\\\"}]");
    if ($urandom_range(3) == 0) put_str(",\"evt\" : \"READY\"");
    put_str("}");
    r = $urandom_range(99);
    if (r < 15) pay_q[$urandom_range(pay_q.size() - 1)] = 8'($urandom_range(255));
    else if (r < 20) void'(pay_q.pop_back());
    else if (r < 25) put_str(($urandom_range(1) != 0) ? "}" : "]");
    else if (r < 30)
      pay_q.insert($urandom_range(pay_q.size() - 1), 8'($urandom_range(31)));
  endtask

  initial begin
    int unsigned frames;
    int unsigned kind;
    logic [31:0] op;
    logic [31:0] len;
    logic        rs;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ping with empty payload, then oversize header, a dead byte, restart
    pay_q.delete();
    send_frame(OP_PING, 32'd0, 1'b0, 1'b0);
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0);
    put_str("{}");
    send_frame(OP_JSON, 32'd2, 1'b1, 1'b0);

    frames = 0;
    while (trk.live_bytes < 1250 || trk.verdicts_seen < 48) begin
      frames++;
      if (frames == 12) hold_req = 1'b1;
      tx_quiet = (frames >= 25 && frames < 35);
      rx_quiet = tx_quiet;

      if (trk.dead && $urandom_range(99) < 30)
        repeat ($urandom_range(4, 1)) send_beat(8'($urandom_range(255)), 1'b0);
      rs = trk.dead || resync || ($urandom_range(99) < 4);
      resync = 1'b0;

      if (frames == 40) begin
        // deeply nested payload
        pay_q.delete();
        put_str("{");
        repeat (60) pay_q.push_back(CH_LBRACK);
        repeat (60) pay_q.push_back(CH_RBRACK);
        put_str("}");
        send_frame(OP_JSON, pay_q.size(), 1'b1, 1'b0);
        continue;
      end

      kind = $urandom_range(99);
      if (kind < 60) begin
        build_json();
        send_frame(OP_JSON, pay_q.size(), rs, 1'b1);
      end else if (kind < 68) begin
        fill_random($urandom_range(6));
        send_frame(OP_PING, pay_q.size(), rs, 1'b1);
      end else if (kind < 76) begin
        fill_random($urandom_range(6));
        send_frame(OP_PONG, pay_q.size(), rs, 1'b1);
      end else if (kind < 82) begin
        case ($urandom_range(3))
          0: op = 32'd0;
          1: op = 32'd2;
          2: op = 32'd5;
          default: op = $urandom;
        endcase
        fill_random($urandom_range(4));
        send_frame(op, pay_q.size(), rs, 1'b1);
      end else if (kind < 88) begin
        case ($urandom_range(2))
          0: len = MAX_PAY + 1;
          1: len = 32'hFFFF_FFFF;
          default: len = $urandom | 32'h0002_0000;
        endcase
        case ($urandom_range(3))
          0: op = OP_JSON;
          1: op = OP_PING;
          2: op = OP_PONG;
          default: op = $urandom;
        endcase
        pay_q.delete();
        send_frame(op, len, rs, 1'b0);
      end else if (kind < 93) begin
        pay_q.delete();
        repeat ($urandom_range(2)) begin
          case ($urandom_range(2))
            0: pay_q.push_back(CH_LBRACE);
            1: pay_q.push_back(CH_RBRACE);
            default: pay_q.push_back(8'($urandom_range(255)));
          endcase
        end
        send_frame(OP_JSON, pay_q.size(), rs, 1'b0);
      end else begin
        // raw noise, realigned by a restart on the next frame
        repeat ($urandom_range(20, 1))
          send_beat(8'($urandom_range(255)), $urandom_range(9) == 0);
        resync = 1'b1;
      end
    end
    in_valid <= 1'b0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    while (trk.verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (trk.verdicts_due.size() != 0)
      trk.flag($sformatf("%0d verdict beats never arrived", trk.verdicts_due.size()));

    if (trk.failures == 0) begin
      $display("[ipc_frame_receiver_classifier] OK");
    end else begin
      $display("[ipc_frame_receiver_classifier] ERROR");
    end
    $finish;
  end

endmodule
